[design/mhacc_pkg.sv]
// Shared types, widths and a helper function for the mesh area accumulator.
`default_nettype none
package mhacc_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int AREA_WIDTH     = 48;
    localparam int NUM_DIFFS      = 9;
    // |p - q| of two signed coordinates
    localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
    // sum of three squared differences
    localparam int SQSUM_WIDTH    = 2 * DIFF_WIDTH + 2;
    localparam int LEN_WIDTH      = (SQSUM_WIDTH + 1) / 2;
    // perimeter a + b + c and the clamped factors
    localparam int PERIM_WIDTH    = LEN_WIDTH + 2;
    localparam int OPER_WIDTH     = 2 * PERIM_WIDTH;
    localparam int RAD_WIDTH      = 2 * OPER_WIDTH;
    localparam int ROOT_WIDTH     = RAD_WIDTH / 2;
    localparam int TRI_AREA_WIDTH = ROOT_WIDTH - 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic                          last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic [AREA_WIDTH-1:0] mesh_area;
        logic                  area_saturated;
    } area_out_t;

    // queue entry: edge a (B-C) in 0..2, edge b (C-A) in 3..5, edge c (A-B) in 6..8
    typedef struct packed {
        logic [NUM_DIFFS-1:0][DIFF_WIDTH-1:0] diff;
        logic                                 last;
    } tri_diff_t;

    typedef struct packed {
        logic                  start;
        logic [OPER_WIDTH-1:0] a;
        logic [OPER_WIDTH-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [RAD_WIDTH-1:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // magnitude of the difference of two signed coordinates
    function automatic logic [DIFF_WIDTH-1:0] coord_absdiff(
        input logic [COORD_WIDTH-1:0] p,
        input logic [COORD_WIDTH-1:0] q
    );
        logic [DIFF_WIDTH-1:0] d;
        d = {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
        return d[DIFF_WIDTH-1] ? (~d + 1'b1) : d;
    endfunction

endpackage
`default_nettype wire

[design/mesh_area_heron_accumulator.sv]
// Top level of the triangle mesh surface area accumulator.
//
//  channel  ports                      payload     direction
//  input    s_valid s_ready s_data     tri_in_t    in  (one triangle)
//  result   m_valid m_ready m_data     area_out_t  out (mesh total on last)
//
// Each triangle runs in the back end as nine squares and three products on a
// one-bit-per-cycle multiplier and four roots on a one-bit-per-cycle square root
// unit, plus the take, perimeter and accumulate steps.
// Reset is synchronous, active low; it empties the queue and clears the total.
// The front queue keeps taking triangles while the back end works; a pending
// total holds the back end only when the next total is ready to leave.
`default_nettype none
module mesh_area_heron_accumulator
    import mhacc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire tri_in_t   s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output area_out_t      m_data
);

    logic      q_valid;
    logic      q_ready;
    tri_diff_t q_data;

    mhacc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    mhacc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

[design/mhacc_front.sv]
// Front end: accepts triangles, forms coordinate differences, queues them.
`default_nettype none
module mhacc_front
    import mhacc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire tri_in_t   s_data,
    output logic           q_valid,
    input  wire logic      q_ready,
    output tri_diff_t      q_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tri_diff_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    tri_diff_t        entry;
    logic             push, pop;

    // classify: differences per edge and the end-of-mesh mark
    always_comb begin
        entry.diff[0] = coord_absdiff(s_data.bx, s_data.cx);
        entry.diff[1] = coord_absdiff(s_data.by, s_data.cy);
        entry.diff[2] = coord_absdiff(s_data.bz, s_data.cz);
        entry.diff[3] = coord_absdiff(s_data.cx, s_data.ax);
        entry.diff[4] = coord_absdiff(s_data.cy, s_data.ay);
        entry.diff[5] = coord_absdiff(s_data.cz, s_data.az);
        entry.diff[6] = coord_absdiff(s_data.ax, s_data.bx);
        entry.diff[7] = coord_absdiff(s_data.ay, s_data.by);
        entry.diff[8] = coord_absdiff(s_data.az, s_data.bz);
        entry.last    = s_data.last_triangle;
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

[design/mhacc_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module mhacc_mul
    import mhacc_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire mul_req_t       req,
    output unit_stat_t          stat,
    output logic [RAD_WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(OPER_WIDTH + 1);

    logic [RAD_WIDTH-1:0]  acc_reg, acc_next;
    logic [RAD_WIDTH-1:0]  mcand_reg, mcand_next;
    logic [OPER_WIDTH-1:0] mplier_reg, mplier_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // one partial product per cycle
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start) begin
            acc_next    = '0;
            mcand_next  = RAD_WIDTH'(req.a);
            mplier_next = req.b;
            cnt_next    = CNT_W'(OPER_WIDTH);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule
`default_nettype wire

[design/mhacc_sqrt.sv]
// Digit-by-digit floor square root, one root bit per cycle.
`default_nettype none
module mhacc_sqrt
    import mhacc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sqrt_req_t       req,
    output unit_stat_t           stat,
    output logic [ROOT_WIDTH-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_WIDTH + 1);

    logic [RAD_WIDTH-1:0]    rad_reg, rad_next;
    logic [ROOT_WIDTH+1:0]   rem_reg, rem_next;
    logic [ROOT_WIDTH-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [ROOT_WIDTH+1:0]   rem_sh, trial;
    logic                    fits;

    assign rem_sh = {rem_reg[ROOT_WIDTH-1:0], rad_reg[RAD_WIDTH-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    // bring down two radicand bits, try the next root bit
    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rad_next  = req.rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = rad_reg << 2;
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_WIDTH-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule
`default_nettype wire

[design/mhacc_back.sv]
// Back end: edge lengths, Heron product, area root, saturating accumulation.
`default_nettype none
module mhacc_back
    import mhacc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      q_valid,
    output logic           q_ready,
    input  wire tri_diff_t q_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output area_out_t      m_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ISSUE = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_ROOT  = 9'b000001000,
        S_PERIM = 9'b000010000,
        S_MX    = 9'b000100000,
        S_MY    = 9'b001000000,
        S_MP    = 9'b010000000,
        S_ACC   = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    tri_diff_t                 entry_reg, entry_next;
    logic [1:0]                edge_reg, edge_next;
    logic [1:0]                comp_reg, comp_next;
    logic [SQSUM_WIDTH-1:0]    sqsum_reg, sqsum_next;
    logic [2:0][LEN_WIDTH-1:0] len_reg, len_next;
    logic [PERIM_WIDTH-1:0]    fb_reg, fb_next;
    logic [PERIM_WIDTH-1:0]    fc_reg, fc_next;
    logic [OPER_WIDTH-1:0]     x_reg, x_next;
    logic [TRI_AREA_WIDTH-1:0] area_reg, area_next;
    logic                      area_pend_reg, area_pend_next;
    logic [AREA_WIDTH-1:0]     sum_reg, sum_next;
    logic                      ovf_reg, ovf_next;
    area_out_t                 out_reg, out_next;
    logic                      m_valid_reg, m_valid_next;

    mul_req_t                  mul_req;
    unit_stat_t                mul_stat;
    logic [RAD_WIDTH-1:0]      product;
    sqrt_req_t                 sqrt_req;
    unit_stat_t                sqrt_stat;
    logic [ROOT_WIDTH-1:0]     root;

    logic [3:0]                diff_idx;
    logic [SQSUM_WIDTH-1:0]    sqsum_add;
    logic [PERIM_WIDTH-1:0]    perim;
    logic [PERIM_WIDTH-1:0]    two_a, two_b, two_c;
    logic [PERIM_WIDTH-1:0]    fa;
    logic [AREA_WIDTH:0]       sum_ext;
    logic [AREA_WIDTH-1:0]     sum_acc;
    logic                      sat;

    mhacc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .product (product)
    );

    mhacc_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .stat    (sqrt_stat),
        .root    (root)
    );

    assign diff_idx  = 4'({2'b00, edge_reg} * 4'd3) + {2'b00, comp_reg};
    assign sqsum_add = sqsum_reg + product[SQSUM_WIDTH-1:0];

    // perimeter and clamped Heron factors
    assign perim = PERIM_WIDTH'(len_reg[0]) + PERIM_WIDTH'(len_reg[1])
                 + PERIM_WIDTH'(len_reg[2]);
    assign two_a = PERIM_WIDTH'({len_reg[0], 1'b0});
    assign two_b = PERIM_WIDTH'({len_reg[1], 1'b0});
    assign two_c = PERIM_WIDTH'({len_reg[2], 1'b0});
    assign fa    = (two_a > perim) ? '0 : perim - two_a;

    // saturating add of the finished triangle
    assign sum_ext = {1'b0, sum_reg} + (AREA_WIDTH + 1)'(area_reg);
    assign sat     = sum_ext[AREA_WIDTH];
    assign sum_acc = sat ? '1 : sum_ext[AREA_WIDTH-1:0];

    assign q_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        edge_next      = edge_reg;
        comp_next      = comp_reg;
        sqsum_next     = sqsum_reg;
        len_next       = len_reg;
        fb_next        = fb_reg;
        fc_next        = fc_reg;
        x_next         = x_reg;
        area_next      = area_reg;
        area_pend_next = area_pend_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mul_req        = '0;
        sqrt_req       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    entry_next = q_data;
                    edge_next  = '0;
                    comp_next  = '0;
                    sqsum_next = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                mul_req.start = 1'b1;
                mul_req.a     = OPER_WIDTH'(entry_reg.diff[diff_idx]);
                mul_req.b     = OPER_WIDTH'(entry_reg.diff[diff_idx]);
                state_next    = S_SQ;
            end
            S_SQ: begin
                if (mul_stat.done) begin
                    sqsum_next = sqsum_add;
                    if (comp_reg == 2'd2) begin
                        sqrt_req.start = 1'b1;
                        sqrt_req.rad   = RAD_WIDTH'(sqsum_add);
                        state_next     = S_ROOT;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ROOT: begin
                if (sqrt_stat.done) begin
                    if (area_pend_reg) begin
                        area_next      = root[ROOT_WIDTH-1:2];
                        area_pend_next = 1'b0;
                        state_next     = S_ACC;
                    end else begin
                        len_next[edge_reg] = root[LEN_WIDTH-1:0];
                        if (edge_reg == 2'd2) begin
                            state_next = S_PERIM;
                        end else begin
                            edge_next  = edge_reg + 1'b1;
                            comp_next  = '0;
                            sqsum_next = '0;
                            state_next = S_ISSUE;
                        end
                    end
                end
            end
            S_PERIM: begin
                fb_next       = (two_b > perim) ? '0 : perim - two_b;
                fc_next       = (two_c > perim) ? '0 : perim - two_c;
                mul_req.start = 1'b1;
                mul_req.a     = OPER_WIDTH'(perim);
                mul_req.b     = OPER_WIDTH'(fa);
                state_next    = S_MX;
            end
            S_MX: begin
                if (mul_stat.done) begin
                    x_next        = product[OPER_WIDTH-1:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = OPER_WIDTH'(fb_reg);
                    mul_req.b     = OPER_WIDTH'(fc_reg);
                    state_next    = S_MY;
                end
            end
            S_MY: begin
                if (mul_stat.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = x_reg;
                    mul_req.b     = product[OPER_WIDTH-1:0];
                    state_next    = S_MP;
                end
            end
            S_MP: begin
                if (mul_stat.done) begin
                    sqrt_req.start = 1'b1;
                    sqrt_req.rad   = product;
                    area_pend_next = 1'b1;
                    state_next     = S_ROOT;
                end
            end
            S_ACC: begin
                if (!entry_reg.last) begin
                    sum_next   = sum_acc;
                    ovf_next   = ovf_reg || sat;
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    out_next.mesh_area      = sum_acc;
                    out_next.area_saturated = ovf_reg || sat;
                    m_valid_next            = 1'b1;
                    sum_next                = '0;
                    ovf_next                = 1'b0;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            area_pend_reg <= 1'b0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            area_pend_reg <= area_pend_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        edge_reg  <= edge_next;
        comp_reg  <= comp_next;
        sqsum_reg <= sqsum_next;
        len_reg   <= len_next;
        fb_reg    <= fb_next;
        fc_reg    <= fc_next;
        x_reg     <= x_next;
        area_reg  <= area_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // the two arithmetic units are never busy together
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && sqrt_stat.busy))
        else $error("multiplier and square root busy at once");

    // a sticky overflow means the total sits at its maximum
    a_sat_holds_max: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (sum_reg == '1))
        else $error("overflow flag set without saturated sum");

    // a pending result is not overwritten
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(out_reg)))
        else $error("pending mesh total changed");

    // queue pops only when a fresh triangle is taken
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> (state_reg == S_ISSUE))
        else $error("triangle popped outside idle");

endmodule
`default_nettype wire
